// ===== hw/rtl/fcpr_pkg.sv =====
// shared types and constants of the filled circle pixel raster
package fcpr_pkg;

    localparam int COORD_W = 6;
    localparam int RAD_W   = 6;
    localparam int COLOR_W = 16;
    localparam int INDEX_W = 2;
    localparam int DIAM_W  = RAD_W + 1;
    localparam int SQ_W    = 2 * RAD_W;

    // register indexes of the configuration port
    localparam logic [INDEX_W-1:0] REG_RADIUS   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_OUTLINE  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_INTERIOR = 2'd2;

    localparam logic [RAD_W-1:0]   RADIUS_RST   = 6'd1;
    localparam logic [COLOR_W-1:0] OUTLINE_RST  = 16'd15;
    localparam logic [COLOR_W-1:0] INTERIOR_RST = 16'd0;

    // one classified query
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [RAD_W-1:0]   radius;
        logic               trivial;
    } job_t;

    typedef struct packed {
        logic [COLOR_W-1:0] outline;
        logic [COLOR_W-1:0] interior;
    } colors_t;

endpackage

// ===== hw/rtl/fcpr_front.sv =====
// query classifier: radius saturation and trivial cases
module fcpr_front #(
    parameter int MAX_DIAMETER = 64
) (
    input  logic [fcpr_pkg::COORD_W-1:0] pixel_row,
    input  logic [fcpr_pkg::COORD_W-1:0] pixel_column,
    input  logic [fcpr_pkg::RAD_W-1:0]   radius,
    input  logic [fcpr_pkg::COLOR_W-1:0] outline,
    output fcpr_pkg::job_t               job
);
    localparam int RMAX = MAX_DIAMETER / 2;

    logic [fcpr_pkg::RAD_W-1:0]  r;
    logic [fcpr_pkg::DIAM_W-1:0] d;

    always_comb
    begin
        if (int'(radius) > RMAX)
            r = fcpr_pkg::RAD_W'(RMAX);
        else
            r = radius;
        d = {r, 1'b0};
        job.row     = pixel_row;
        job.col     = pixel_column;
        job.radius  = r;
        job.trivial = (r == '0) || ({1'b0, pixel_row} >= d) ||
                      ({1'b0, pixel_column} >= d) || (outline == '0);
    end
endmodule

// ===== hw/rtl/fcpr_queue.sv =====
// two-entry job queue between classifier and raster engine
module fcpr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  fcpr_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_en,
    output logic           has_job,
    output fcpr_pkg::job_t rd_job
);
    fcpr_pkg::job_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign has_job = (count_reg != 2'd0);
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== hw/rtl/fcpr_back.sv =====
// raster engine: outline walk of the row, column scan, result register
module fcpr_back #(
    parameter int MAX_DIAMETER = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         has_job,
    input  fcpr_pkg::job_t               job,
    output logic                         take_job,
    input  fcpr_pkg::colors_t            colors,
    input  logic                         pop,
    output logic                         empty,
    output logic [fcpr_pkg::COLOR_W-1:0] pixel_color
);
    localparam int LINE_N = (MAX_DIAMETER < 126) ? MAX_DIAMETER : 126;
    localparam int IDX_W  = (LINE_N > 1) ? $clog2(LINE_N) : 1;
    localparam int DW     = fcpr_pkg::DIAM_W;
    localparam int SW     = fcpr_pkg::SQ_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROOT = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // column scan phases
    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_RUN    = 2'd1;
    localparam logic [1:0] PH_SPAN   = 2'd2;
    localparam logic [1:0] PH_BLOCK  = 2'd3;

    state_t                        state_reg, state_next;
    fcpr_pkg::job_t                job_reg, job_next;
    logic [fcpr_pkg::RAD_W-1:0]    k_reg, k_next;
    logic [fcpr_pkg::RAD_W-1:0]    x_reg, x_next;
    logic [SW-1:0]                 rr_reg, rr_next;
    logic [LINE_N-1:0]             line_reg, line_next;
    logic [DW-1:0]                 m_reg, m_next;
    logic [1:0]                    phase_reg, phase_next;
    logic [fcpr_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic [fcpr_pkg::COLOR_W-1:0]  out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic [SW-1:0] kk, xx, n;
    logic [DW-1:0] r7, k7, x7, row7, a, b, c, e, d;
    logic          bit_m;

    assign empty       = !out_valid_reg;
    assign pixel_color = out_reg;

    always_comb
    begin
        r7    = DW'(job_reg.radius);
        k7    = DW'(k_reg);
        x7    = DW'(x_reg);
        row7  = DW'(job_reg.row);
        d     = {job_reg.radius, 1'b0};
        kk    = SW'(k_reg) * SW'(k_reg);
        xx    = SW'(x_reg) * SW'(x_reg) - SW'(x_reg);
        n     = rr_reg - kk;
        a     = r7 - k7;
        b     = r7 + k7 - DW'(1);
        c     = r7 - x7;
        e     = r7 + x7 - DW'(1);
        bit_m = line_reg[m_reg[IDX_W-1:0]];

        state_next     = state_reg;
        job_next       = job_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        rr_next        = rr_reg;
        line_next      = line_reg;
        m_next         = m_reg;
        phase_next     = phase_reg;
        color_next     = color_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        take_job       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (has_job)
                begin
                    take_job   = 1'b1;
                    job_next   = job;
                    k_next     = fcpr_pkg::RAD_W'(1);
                    x_next     = job.radius;
                    rr_next    = SW'(job.radius) * SW'(job.radius);
                    line_next  = '0;
                    m_next     = '0;
                    phase_next = PH_BEFORE;
                    color_next = '0;
                    state_next = job.trivial ? S_DONE : S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (x_reg != '0 && xx >= n)
                    x_next = x_reg - fcpr_pkg::RAD_W'(1);
                else
                begin
                    if (row7 == a || row7 == b)
                    begin
                        line_next[c[IDX_W-1:0]] = 1'b1;
                        line_next[e[IDX_W-1:0]] = 1'b1;
                    end
                    if (row7 == c || row7 == e)
                    begin
                        line_next[a[IDX_W-1:0]] = 1'b1;
                        line_next[b[IDX_W-1:0]] = 1'b1;
                    end
                    if (k_reg == job_reg.radius)
                        state_next = S_SCAN;
                    else
                        k_next = k_reg + fcpr_pkg::RAD_W'(1);
                end
            end
            S_SCAN:
            begin
                case (phase_reg)
                    PH_BEFORE: phase_next = bit_m ? PH_RUN : PH_BEFORE;
                    PH_RUN:    phase_next = bit_m ? PH_RUN : PH_SPAN;
                    PH_SPAN:   phase_next = bit_m ? PH_BLOCK : PH_SPAN;
                    default:   phase_next = PH_BLOCK;
                endcase
                if (m_reg == DW'(job_reg.col))
                begin
                    if (bit_m)
                        color_next = colors.outline;
                    else if (row7 == '0 || row7 == d - DW'(1))
                        color_next = '0;
                    else if (phase_next == PH_SPAN)
                        color_next = colors.interior;
                    else
                        color_next = '0;
                    state_next = S_DONE;
                end
                else
                    m_next = m_reg + DW'(1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = color_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        k_reg     <= k_next;
        x_reg     <= x_next;
        rr_reg    <= rr_next;
        line_reg  <= line_next;
        m_reg     <= m_next;
        phase_reg <= phase_next;
        color_reg <= color_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT |-> (k_reg != '0 && k_reg <= job_reg.radius))
        else $error("outline walk index out of range");

    a_x_descends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT |=> (state_reg != S_ROOT || x_reg <= $past(x_reg)))
        else $error("outline offset increased");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> m_reg <= DW'(job_reg.col))
        else $error("scan passed the queried column");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result overwritten");
endmodule

// ===== hw/rtl/filled_circle_pixel_raster.sv =====
// filled circle pixel raster top level: config registers, classifier, queue, engine
// trivial queries (outside raster, zero radius/outline) go straight from take to result load
// other queries: take, outline walk (k steps, x steps), scan of columns 0 up to the queried
// column, result load; a new query is taken only after the last result is loaded
// one query is worked at a time; two more wait in the job queue
// rst_n clears control state and sets radius 1, outline color 15, interior color 0
module filled_circle_pixel_raster #(
    parameter int MAX_DIAMETER = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // query side, a transfer when push and not full
    input  logic                          push,
    output logic                          full,
    input  logic [fcpr_pkg::COORD_W-1:0]  pixel_row,
    input  logic [fcpr_pkg::COORD_W-1:0]  pixel_column,
    // result side, a transfer when pop and not empty
    output logic                          empty,
    input  logic                          pop,
    output logic [fcpr_pkg::COLOR_W-1:0]  pixel_color,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fcpr_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [fcpr_pkg::COLOR_W-1:0]  cfg_data
);
    logic [fcpr_pkg::RAD_W-1:0]   radius_reg, radius_next;
    logic [fcpr_pkg::COLOR_W-1:0] outline_reg, outline_next;
    logic [fcpr_pkg::COLOR_W-1:0] interior_reg, interior_next;

    fcpr_pkg::job_t    front_job, queue_job;
    fcpr_pkg::colors_t colors;
    logic              has_job, take_job, accept;

    // registers always take a write; unknown indexes drop the data
    assign cfg_ready = 1'b1;

    always_comb
    begin
        radius_next   = radius_reg;
        outline_next  = outline_reg;
        interior_next = interior_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                fcpr_pkg::REG_RADIUS:   radius_next   = cfg_data[fcpr_pkg::RAD_W-1:0];
                fcpr_pkg::REG_OUTLINE:  outline_next  = cfg_data;
                fcpr_pkg::REG_INTERIOR: interior_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= fcpr_pkg::RADIUS_RST;
            outline_reg  <= fcpr_pkg::OUTLINE_RST;
            interior_reg <= fcpr_pkg::INTERIOR_RST;
        end
        else
        begin
            radius_reg   <= radius_next;
            outline_reg  <= outline_next;
            interior_reg <= interior_next;
        end
    end

    assign colors.outline  = outline_reg;
    assign colors.interior = interior_reg;
    assign accept          = push && !full;

    // front: saturate radius and flag queries answered by a plain zero
    fcpr_front #(.MAX_DIAMETER(MAX_DIAMETER)) u_front (
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .radius       (radius_reg),
        .outline      (outline_reg),
        .job          (front_job)
    );

    // decouples query transfers from the engine
    fcpr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_job  (front_job),
        .full    (full),
        .rd_en   (take_job),
        .has_job (has_job),
        .rd_job  (queue_job)
    );

    // back: rebuild the queried row, scan to the column, hold the result
    fcpr_back #(.MAX_DIAMETER(MAX_DIAMETER)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .has_job     (has_job),
        .job         (queue_job),
        .take_job    (take_job),
        .colors      (colors),
        .pop         (pop),
        .empty       (empty),
        .pixel_color (pixel_color)
    );
endmodule

// ===== verif/fcpr_checker.sv =====
// checker for the filled circle pixel raster: pixel color prediction and result compare
module fcpr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic [fcpr_pkg::COORD_W-1:0] pixel_row,
    input  logic [fcpr_pkg::COORD_W-1:0] pixel_column,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [fcpr_pkg::COLOR_W-1:0] pixel_color,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [fcpr_pkg::INDEX_W-1:0] cfg_index,
    input  logic [fcpr_pkg::COLOR_W-1:0] cfg_data,
    output int                           error_count,
    output int                           pending_colors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_SPAN = 32;

    logic [fcpr_pkg::RAD_W-1:0]   radius_q;
    logic [fcpr_pkg::COLOR_W-1:0] outline_q;
    logic [fcpr_pkg::COLOR_W-1:0] interior_q;
    logic [fcpr_pkg::COLOR_W-1:0] color_fifo[$];

    function automatic int rounded_root(int n);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) <= n)
            s++;
        if (n > s * s + s)
            s++;
        return s;
    endfunction

    function automatic logic [fcpr_pkg::COLOR_W-1:0] predict_color(int row, int col);
        logic line[64];
        int   r, d, x, a, b, c, e, i, j;
        r = radius_q;
        if (r > HALF_SPAN)
            r = HALF_SPAN;
        d = 2 * r;
        if (r == 0 || row >= d || col >= d || outline_q == '0)
            return '0;
        for (i = 0; i < 64; i++)
            line[i] = 1'b0;
        for (int k = 1; k <= r; k++)
        begin
            x = rounded_root(r * r - k * k);
            a = r - k;
            b = r + k - 1;
            c = r - x;
            e = r + x - 1;
            if (row == a || row == b)
            begin
                if (c < d) line[c] = 1'b1;
                if (e < d) line[e] = 1'b1;
            end
            if (row == c || row == e)
            begin
                if (a < d) line[a] = 1'b1;
                if (b < d) line[b] = 1'b1;
            end
        end
        if (line[col])
            return outline_q;
        if (row == 0 || row == d - 1)
            return '0;
        for (i = 0; i < d && !line[i]; i++);
        if (i >= d)
            return '0;
        for (j = i; j < d && line[j]; j++);
        if (j >= d || col < j)
            return '0;
        for (int m = j; m <= col; m++)
            if (line[m])
                return '0;
        return interior_q;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    assign pending_colors = color_fifo.size();

    initial error_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_q   <= fcpr_pkg::RADIUS_RST;
            outline_q  <= fcpr_pkg::OUTLINE_RST;
            interior_q <= fcpr_pkg::INTERIOR_RST;
            color_fifo.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fcpr_pkg::REG_RADIUS:   radius_q   <= cfg_data[fcpr_pkg::RAD_W-1:0];
                    fcpr_pkg::REG_OUTLINE:  outline_q  <= cfg_data;
                    fcpr_pkg::REG_INTERIOR: interior_q <= cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                color_fifo.push_back(predict_color(pixel_row, pixel_column));
            if (pop && !empty)
            begin
                if (color_fifo.size() == 0)
                    report_mismatch($sformatf("unexpected color %h", pixel_color));
                else if (color_fifo[0] !== pixel_color)
                begin
                    report_mismatch($sformatf("color %h, want %h",
                        pixel_color, color_fifo[0]));
                    void'(color_fifo.pop_front());
                end
                else
                    void'(color_fifo.pop_front());
            end
        end
    end
endmodule

// ===== verif/tb_filled_circle_pixel_raster.sv =====
// testbench top for the filled circle pixel raster: stimulus, config phases, verdict
module tb_filled_circle_pixel_raster;
    timeunit 1ns;
    timeprecision 1ps;

    // no transfer on any channel for this many cycles ends the run
    localparam int STALL_LIMIT = 20000;
    // worst query walk plus column scan, with margin
    localparam int DRAIN_CYCLES = 200;

    logic                         clk;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic [fcpr_pkg::COORD_W-1:0] pixel_row;
    logic [fcpr_pkg::COORD_W-1:0] pixel_column;
    logic                         empty;
    logic                         pop;
    logic [fcpr_pkg::COLOR_W-1:0] pixel_color;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [fcpr_pkg::INDEX_W-1:0] cfg_index;
    logic [fcpr_pkg::COLOR_W-1:0] cfg_data;
    int                           error_count;
    int                           pending_colors;
    int                           quiet_cycles;
    bit                           steady_pop;    // long stretch with the receiver never stalling

    filled_circle_pixel_raster u_top (.*);

    fcpr_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls about a quarter of the time, except in the steady stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= steady_pop || ($urandom_range(99) >= 26);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one register transfer, only while the block is idle
    task automatic write_register(logic [fcpr_pkg::INDEX_W-1:0] idx,
                                  logic [fcpr_pkg::COLOR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one query transfer; idle cycles go in front when gaps are wanted
    task automatic send_query(int row, int col, bit gaps);
        if (gaps)
            while ($urandom_range(99) < 26)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        push         <= 1'b1;
        pixel_row    <= row[fcpr_pkg::COORD_W-1:0];
        pixel_column <= col[fcpr_pkg::COORD_W-1:0];
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // drain every expected color, then let the engine settle
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_colors != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_circle(int radius, int outline, int interior);
        write_register(fcpr_pkg::REG_RADIUS, radius[fcpr_pkg::COLOR_W-1:0]);
        write_register(fcpr_pkg::REG_OUTLINE, outline[fcpr_pkg::COLOR_W-1:0]);
        write_register(fcpr_pkg::REG_INTERIOR, interior[fcpr_pkg::COLOR_W-1:0]);
    endtask

    // mostly queries inside the raster, some anywhere in the coordinate range
    task automatic random_queries(int count, int radius, bit gaps);
        int span;
        span = (radius > 32) ? 64 : 2 * radius;
        for (int n = 0; n < count; n++)
        begin
            if (span > 0 && $urandom_range(99) < 80)
                send_query($urandom_range(span - 1), $urandom_range(span - 1), gaps);
            else
                send_query($urandom_range(63), $urandom_range(63), gaps);
        end
    endtask

    initial
    begin
        int radius;
        rst_n        = 1'b0;
        push         = 1'b0;
        pixel_row    = '0;
        pixel_column = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady_pop   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: radius 1, three of the four raster cells plus outside
        send_query(0, 0, 0);
        send_query(1, 1, 0);
        send_query(0, 1, 0);
        send_query(2, 0, 0);
        send_query(63, 63, 0);
        settle();

        // largest radius with extreme colors: corners, full rows, edges
        set_circle(32, 16'hffff, 16'h0001);
        send_query(0, 0, 0);
        send_query(0, 31, 0);
        send_query(63, 32, 0);
        send_query(32, 0, 0);
        send_query(32, 63, 0);
        send_query(31, 31, 0);
        send_query(10, 40, 1);
        send_query(63, 63, 0);
        settle();

        // zero radius, radius that saturates, zero outline
        write_register(fcpr_pkg::REG_RADIUS, 16'd0);
        send_query(0, 0, 0);
        send_query(5, 5, 0);
        settle();
        set_circle(63, 16'h8000, 16'hfffe);
        send_query(31, 31, 0);
        send_query(0, 31, 0);
        send_query(40, 63, 0);
        settle();
        set_circle(5, 16'h0000, 16'h1234);
        send_query(5, 5, 0);
        send_query(0, 4, 0);
        settle();

        // unknown index must be ignored
        write_register(2'd3, 16'hffff);
        set_circle(3, 16'h00aa, 16'h5500);
        send_query(2, 2, 0);
        send_query(0, 2, 0);
        send_query(5, 3, 0);
        send_query(6, 0, 0);
        settle();

        // random phases, mostly small radii, extremes included
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: radius = 1;
                1: radius = 32;
                2: radius = 0;
                3: radius = 63;
                default: radius = $urandom_range(2, 12);
            endcase
            if (phase == 4)
                set_circle(radius, $urandom_range(1, 65535), $urandom_range(65535));
            else if (phase == 5)
                set_circle(radius, 0, $urandom_range(65535));
            else
                set_circle(radius, $urandom_range(65535), $urandom_range(65535));
            // phase 6 runs with no idling on either side
            steady_pop <= (phase == 6);
            random_queries(50, radius, phase != 6);
            settle();
        end
        steady_pop <= 1'b0;
        settle();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
